>>> rtl/lgtr_pkg.sv
package lgtr_pkg;
    localparam int MaxTopics  = 16;
    localparam int TopicBits  = 4;
    localparam int DocBits    = 10;
    localparam int WordBits   = 12;
    localparam int CountBits  = 16;
    localparam int ScoreBits  = 48;
    localparam int SumBits    = 64;
    localparam int CfgIdxBits = 1;

    localparam logic [1:0] OpLoad   = 2'd0;
    localparam logic [1:0] OpAdd    = 2'd1;
    localparam logic [1:0] OpSample = 2'd2;
    localparam logic [1:0] OpRead   = 2'd3;

    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StUnderflow = 2'd1;
    localparam logic [1:0] StBadTopic  = 2'd2;

    localparam logic [CfgIdxBits-1:0] CfgAlpha  = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgTopics = 1'd1;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [DocBits-1:0]   doc_index;
        logic [WordBits-1:0]  word_index;
        logic [TopicBits-1:0] topic;
        logic [15:0]          value;
    } t_in;

    typedef struct packed {
        logic [TopicBits-1:0] new_topic;
        logic [15:0]          count;
        logic [1:0]           status;
    } t_out;
endpackage

>>> rtl/lgtr_if.sv
interface lgtr_if_in;
    logic          valid;
    logic          ready;
    lgtr_pkg::t_in data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lgtr_if_out;
    logic           valid;
    logic           ready;
    lgtr_pkg::t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/lgtr_mul.sv
// Shared multiplier with a registered product; 32x16 bits.
module lgtr_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [15:0] i_b,
    output logic [47:0] o_p
);
    logic [47:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= 48'(i_a) * 48'(i_b);
    end
    assign o_p = r_p;
endmodule

>>> rtl/lda_gibbs_topic_resampler_unit.sv
// Load and read go straight from execute to the result, and add writes the count row
// back first; resample scores the K topics in use, scales the sum and walks between 1
// and K topics before it picks one. The cost is set by one shared 32x16 multiplier and one
// read port on each of the count and weight memories. After reset a clearing pass
// over all 1024 document rows (one document row a cycle) runs before the first item is
// accepted. Results wait in an output register, and no new item is taken until the
// waiting result beat has been accepted.
module lda_gibbs_topic_resampler_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [lgtr_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    lgtr_if_in.sink       in_ch,
    lgtr_if_out.source    out_ch
);
    localparam int TB = lgtr_pkg::TopicBits;
    localparam int CB = lgtr_pkg::CountBits;
    localparam int DB = lgtr_pkg::DocBits;
    localparam int RowBits = CB * lgtr_pkg::MaxTopics;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001, S_IDLE  = 10'b0000000010,
        S_RDROW = 10'b0000000100, S_EXEC  = 10'b0000001000,
        S_SCORE = 10'b0000010000, S_SCALE = 10'b0000100000,
        S_SCL2  = 10'b0001000000, S_WALK  = 10'b0010000000,
        S_WRITE = 10'b0100000000, S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_alpha;
    logic [4:0]  r_ntop;
    logic [DB:0] r_clr;
    lgtr_pkg::t_in r_in;
    lgtr_pkg::t_out r_out;
    logic r_ov;

    // Counts: one row of all topics per document.
    logic [RowBits-1:0] r_cnt_mem [1 << DB];
    logic [RowBits-1:0] r_row;
    logic [15:0] r_w_mem [1 << (TB + lgtr_pkg::WordBits)];
    logic [15:0] r_w;
    logic [lgtr_pkg::ScoreBits-1:0] r_sc [lgtr_pkg::MaxTopics];
    logic [63:0] r_sum, r_rest;
    logic [TB:0] r_t;
    logic [2:0]  r_ph;
    logic [1:0]  r_st;

    logic [4:0] k;
    assign k = (r_ntop == 5'd0) ? 5'd1 : (r_ntop > 5'd16) ? 5'd16 : r_ntop;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    lgtr_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    function automatic logic [CB-1:0] cnt_of(logic [RowBits-1:0] row, logic [TB-1:0] t);
        cnt_of = row[t*CB +: CB];
    endfunction
    function automatic logic [CB-1:0] bump(logic [CB-1:0] c);
        bump = (c == {CB{1'b1}}) ? c : c + 1'b1;
    endfunction

    always_comb begin
        mul_a = {cnt_of(r_row, r_t[TB-1:0]), r_alpha};
        mul_b = r_w;
        if (r_state == S_SCALE) begin
            mul_a = {16'd0, r_sum[63:48]}; mul_b = r_in.value;
        end else if (r_state == S_SCL2) begin
            mul_a = (r_ph == 3'd0) ? r_sum[47:16] : {16'd0, r_sum[15:0]};
            mul_b = r_in.value;
        end
    end

    assign in_ch.ready = (r_state == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_out;

    logic [CB-1:0] cur;
    logic [63:0] sadd;
    logic [64:0] swide;
    assign cur = cnt_of(r_row, r_in.topic);
    assign swide = {1'b0, r_sum} + 65'(mul_p);
    assign sadd = swide[64] ? {64{1'b1}} : swide[63:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCORE && r_ph == 3'd0) begin
            r_w <= r_w_mem[{r_t[TB-1:0], r_in.word_index}];
        end
        if (r_state == S_EXEC && r_in.opcode == lgtr_pkg::OpLoad
                && {1'b0, r_in.topic} < k) begin
            r_w_mem[{r_in.topic, r_in.word_index}] <= r_in.value;
        end
        if (r_state == S_CLEAR) begin
            r_cnt_mem[r_clr[DB-1:0]] <= '0;
        end else if (r_state == S_WRITE) begin
            r_cnt_mem[r_in.doc_index] <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_alpha <= 16'd6554;
            r_ntop  <= 5'd10;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == lgtr_pkg::CfgAlpha) r_alpha <= i_cfg_data;
                else if (i_cfg_index == lgtr_pkg::CfgTopics) r_ntop <= i_cfg_data[4:0];
            end
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            else if (r_state == S_OUT) r_ov <= 1'b1;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[DB-1:0] == {DB{1'b1}}) r_state <= S_IDLE;
                end
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_in <= in_ch.data;
                    r_state <= S_RDROW;
                end
                S_RDROW: begin
                    r_row <= r_cnt_mem[r_in.doc_index];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_out.new_topic <= r_in.topic;
                    if ({1'b0, r_in.topic} >= k) begin
                        r_out.status <= lgtr_pkg::StBadTopic;
                        r_out.count <= '0;
                        r_state <= S_OUT;
                    end else begin
                        case (r_in.opcode)
                            lgtr_pkg::OpAdd: begin
                                r_row[r_in.topic*CB +: CB] <= bump(cur);
                                r_out.status <= lgtr_pkg::StOk;
                                r_out.count <= 16'(bump(cur));
                                r_state <= S_WRITE;
                            end
                            lgtr_pkg::OpSample: begin
                                r_st <= (cur == '0) ? lgtr_pkg::StUnderflow : lgtr_pkg::StOk;
                                if (cur != '0) r_row[r_in.topic*CB +: CB] <= cur - 1'b1;
                                r_sum <= '0; r_t <= '0; r_ph <= 3'd0;
                                r_state <= S_SCORE;
                            end
                            default: begin
                                r_out.status <= lgtr_pkg::StOk;
                                r_out.count <= 16'(cur);
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // Per topic: read weight, multiply, accumulate.
                S_SCORE: begin
                    if (r_ph == 3'd2) begin
                        r_sc[r_t[TB-1:0]] <= mul_p;
                        r_sum <= sadd;
                        r_ph <= 3'd0;
                        r_t <= r_t + 1'b1;
                        if (r_t + 1'b1 == k) begin
                            r_state <= S_SCALE;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                // scaled = (sum>>16)*v + ((sum&0xFFFF)*v >> 16), in three products.
                S_SCALE: begin
                    r_ph <= 3'd0;
                    r_state <= S_SCL2;
                end
                S_SCL2: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd0) r_rest <= {mul_p[31:0], 32'd0};
                    else if (r_ph == 3'd1) r_rest <= r_rest + {16'd0, mul_p};
                    else begin
                        r_rest <= r_rest + {48'd0, mul_p[31:16]};
                        r_t <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_t + 1'b1 >= k || r_rest <= 64'(r_sc[r_t[TB-1:0]])) begin
                        r_row[r_t[TB-1:0]*CB +: CB] <= bump(cnt_of(r_row, r_t[TB-1:0]));
                        r_out.new_topic <= r_t[TB-1:0];
                        r_out.count <= 16'(bump(cnt_of(r_row, r_t[TB-1:0])));
                        r_out.status <= r_st;
                        r_state <= S_WRITE;
                    end else begin
                        r_rest <= r_rest - 64'(r_sc[r_t[TB-1:0]]);
                        r_t <= r_t + 1'b1;
                    end
                end
                S_WRITE: r_state <= S_OUT;
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_out.status != 2'd3) else $error("bad status");
    a_bad_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.status == lgtr_pkg::StBadTopic |-> r_out.count == 16'd0)
        else $error("bad topic count nonzero");
endmodule

>>> sim/lda_gibbs_topic_resampler_unit_tb.sv
`timescale 1ns / 1ps

module lda_gibbs_topic_resampler_unit_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [lgtr_pkg::CfgIdxBits-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    lgtr_if_in  in_ch ();
    lgtr_if_out out_ch ();

    lda_gibbs_topic_resampler_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Shadow state of the block.
    logic [15:0] weight_mem [int];
    logic [15:0] doc_counts [int];
    logic [15:0] alpha_reg = 16'd6554;
    logic [4:0]  topics_reg = 5'd10;

    lgtr_pkg::t_in  beat_queue [$];
    lgtr_pkg::t_out expected_q [$];
    int   error_count = 0;
    int   results_seen = 0;
    bit   hold_off = 1'b0;
    bit   loaded [int];

    function automatic logic [15:0] get_count(int key);
        return doc_counts.exists(key) ? doc_counts[key] : 16'd0;
    endfunction

    function automatic int topics_eff();
        return (topics_reg == 0) ? 1 :
               (topics_reg > lgtr_pkg::MaxTopics) ? lgtr_pkg::MaxTopics : int'(topics_reg);
    endfunction

    function automatic lgtr_pkg::t_out predict_topic(lgtr_pkg::t_in it);
        lgtr_pkg::t_out r;
        int k, row, t;
        logic [63:0] sum, scaled, rest, s;
        logic [63:0] scores [lgtr_pkg::MaxTopics];
        logic [15:0] c;
        k = topics_eff();
        row = int'(it.doc_index) * lgtr_pkg::MaxTopics;
        r.new_topic = it.topic;
        r.status = lgtr_pkg::StOk;
        r.count = '0;
        if (it.topic >= k) begin
            r.status = lgtr_pkg::StBadTopic;
        end else if (it.opcode == lgtr_pkg::OpLoad) begin
            weight_mem[int'(it.topic) * 4096 + int'(it.word_index)] = it.value;
            r.count = get_count(row + it.topic);
        end else if (it.opcode == lgtr_pkg::OpAdd) begin
            c = get_count(row + it.topic);
            if (c != 16'hFFFF) c++;
            doc_counts[row + it.topic] = c;
            r.count = c;
        end else if (it.opcode == lgtr_pkg::OpRead) begin
            r.count = get_count(row + it.topic);
        end else begin
            c = get_count(row + it.topic);
            if (c == 0) r.status = lgtr_pkg::StUnderflow;
            else doc_counts[row + it.topic] = c - 16'd1;
            sum = '0;
            for (t = 0; t < k; t++) begin
                s = (({48'd0, get_count(row + t)} << 16) + alpha_reg) *
                    weight_mem[t * 4096 + int'(it.word_index)];
                sum = (sum > ~64'd0 - s) ? ~64'd0 : sum + s;
                scores[t] = s;
            end
            scaled = (sum >> 16) * it.value + (((sum & 64'hFFFF) * it.value) >> 16);
            rest = scaled;
            for (t = 0; t + 1 < k; t++) begin
                if (rest <= scores[t]) break;
                rest -= scores[t];
            end
            r.new_topic = 4'(t);
            c = get_count(row + t);
            if (c != 16'hFFFF) c++;
            doc_counts[row + t] = c;
            r.count = c;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic queue_beat(lgtr_pkg::t_in it);
        beat_queue = {beat_queue, it};
    endtask

    // Driver: the predictor runs when a beat is accepted.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (in_ch.valid && in_ch.ready) begin
            expected_q = {expected_q, predict_topic(in_ch.data)};
            send_gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
            if (send_gap == 0 && beat_queue.size() > 0) begin
                in_ch.data <= beat_queue.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end else if (!in_ch.valid && beat_queue.size() > 0) begin
            if (send_gap > 0) send_gap--;
            else begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= beat_queue.pop_front();
            end
        end
    end

    // Monitor.
    int recv_gap = 0;
    lgtr_pkg::t_out want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat, topic", out_ch.data.new_topic, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.data.new_topic !== want.new_topic)
                        report_mismatch("new_topic", out_ch.data.new_topic, want.new_topic);
                    if (out_ch.data.count !== want.count)
                        report_mismatch("count", out_ch.data.count, want.count);
                    if (out_ch.data.status !== want.status)
                        report_mismatch("status", out_ch.data.status, want.status);
                end
                recv_gap = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (hold_off) out_ch.ready <= 1'b0;
            else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else out_ch.ready <= 1'b1;
        end
    end

    // Long receiver stall, counted in its own process.
    initial begin
        wait (results_seen >= 300);
        hold_off = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic lgtr_pkg::t_in make_item(logic [1:0] op, int doc, int word, int topic,
                                                int val);
        lgtr_pkg::t_in it;
        it.opcode = op;
        it.doc_index = 10'(doc);
        it.word_index = 12'(word);
        it.topic = 4'(topic);
        it.value = 16'(val);
        return it;
    endfunction

    task automatic write_reg(logic [lgtr_pkg::CfgIdxBits-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == lgtr_pkg::CfgAlpha) alpha_reg = data;
        else topics_reg = data[4:0];
    endtask

    task automatic drain;
        wait (beat_queue.size() == 0 && !in_ch.valid && expected_q.size() == 0);
        repeat (150) @(posedge i_clk);
    endtask

    // Loads every weight a phase's sampling can touch, for the chosen words. Loads of
    // topics beyond the current setting are refused by the block, so they stay unloaded.
    task automatic load_words(int words[$]);
        int k_eff;
        k_eff = topics_eff();
        foreach (words[w])
            for (int t = 0; t < lgtr_pkg::MaxTopics; t++)
                if (!loaded.exists(t * 4096 + words[w])) begin
                    queue_beat(make_item(lgtr_pkg::OpLoad, $urandom_range(0, 1023),
                                         words[w], t, $urandom_range(0, 65535)));
                    if (t < k_eff) loaded[t * 4096 + words[w]] = 1'b1;
                end
    endtask

    // Random sample-heavy traffic, with loads and samples on the known words; topics may
    // exceed the setting, which exercises the bad-topic path.
    task automatic random_phase(int n, int words[$]);
        int r, d;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
            if (r < 15)
                queue_beat(make_item(lgtr_pkg::OpAdd, d, $urandom_range(0, 4095),
                                     $urandom_range(0, 15), $urandom_range(0, 65535)));
            else if (r < 25)
                queue_beat(make_item(lgtr_pkg::OpRead, d, $urandom_range(0, 4095),
                                     $urandom_range(0, 15), $urandom_range(0, 65535)));
            else if (r < 30)
                queue_beat(make_item(lgtr_pkg::OpLoad, d, words[$urandom_range(0,
                                     words.size() - 1)], $urandom_range(0, 15),
                                     $urandom_range(0, 65535)));
            else
                queue_beat(make_item(lgtr_pkg::OpSample, d, words[$urandom_range(0,
                                     words.size() - 1)], $urandom_range(0, 15),
                                     ($urandom_range(0, 9) == 0) ? 0 :
                                     $urandom_range(0, 65535)));
        end
    endtask

    int words [$];
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings, on the extreme words 0 and 4095.
        words = '{0, 4095, 1365, 2730, 7, 100};
        load_words('{0, 4095});
        queue_beat(make_item(lgtr_pkg::OpRead, 1023, 0, 9, 0));
        queue_beat(make_item(lgtr_pkg::OpAdd, 1023, 0, 9, 65535));
        queue_beat(make_item(lgtr_pkg::OpSample, 1023, 4095, 9, 65535));
        queue_beat(make_item(lgtr_pkg::OpSample, 0, 0, 3, 0));
        queue_beat(make_item(lgtr_pkg::OpSample, 0, 0, 3, 0));
        queue_beat(make_item(lgtr_pkg::OpAdd, 5, 4095, 15, 0));
        queue_beat(make_item(lgtr_pkg::OpLoad, 5, 4095, 10, 1));
        queue_beat(make_item(lgtr_pkg::OpRead, 0, 0, 0, 0));
        drain();

        write_reg(lgtr_pkg::CfgTopics, 16'd16);
        write_reg(lgtr_pkg::CfgAlpha, 16'd65535);
        load_words(words);
        random_phase(300, words);
        drain();

        write_reg(lgtr_pkg::CfgTopics, 16'd1);
        write_reg(lgtr_pkg::CfgAlpha, 16'd1);
        random_phase(150, words);
        drain();

        // Zero acts as one topic, large values clamp to sixteen.
        write_reg(lgtr_pkg::CfgTopics, 16'd0);
        random_phase(50, words);
        drain();
        write_reg(lgtr_pkg::CfgTopics, 16'd31);
        random_phase(100, words);
        drain();

        write_reg(lgtr_pkg::CfgTopics, 16'd10);
        write_reg(lgtr_pkg::CfgAlpha, 16'd6554);
        random_phase(300, words);
        // Stack many assignments on one count, then sample against it.
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 16; j++)
                queue_beat(make_item(lgtr_pkg::OpAdd, 2, 0, 1, 0));
        drain();
        write_reg(lgtr_pkg::CfgTopics, 16'd4);
        write_reg(lgtr_pkg::CfgAlpha, 16'd32768);
        random_phase(300, words);
        drain();

        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #100ms;
        $display("FAILURE");
        $finish;
    end
endmodule
